### hdl/eucd4d_pkg.sv
package eucd4d_pkg;

  localparam int unsigned DIMENSIONS = 4;

endpackage

### hdl/eucd4d_sqrt.sv
module eucd4d_sqrt #(
  parameter int unsigned ROOT_WIDTH = 17
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [2*ROOT_WIDTH-1:0]   radicand_i,
  output logic                      valid_o,
  output logic [ROOT_WIDTH-1:0]     root_o
);

  localparam int unsigned RadW = 2 * ROOT_WIDTH;
  localparam int unsigned RemW = ROOT_WIDTH + 2;

  logic [RadW-1:0]       rad_q  [ROOT_WIDTH+1];
  logic [RemW-1:0]       rem_q  [ROOT_WIDTH+1];
  logic [ROOT_WIDTH-1:0] root_q [ROOT_WIDTH+1];
  logic [ROOT_WIDTH:0]   vld_q;

  // entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= radicand_i;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
  end

  // one root bit per stage
  for (genvar g = 0; g < ROOT_WIDTH; g++) begin : g_step
    logic [RemW+1:0]       rem_sh;
    logic [RemW+1:0]       trial;
    logic [RemW+1:0]       rem_sub;
    logic                  fits;
    logic [RemW-1:0]       rem_d;
    logic [ROOT_WIDTH-1:0] root_d;
    logic [RadW-1:0]       rad_d;

    always_comb begin
      rem_sh  = {rem_q[g], rad_q[g][RadW-1 -: 2]};
      trial   = {2'b00, root_q[g], 2'b01};
      rem_sub = rem_sh - trial;
      fits    = (rem_sh >= trial);
      rem_d   = fits ? rem_sub[RemW-1:0] : rem_sh[RemW-1:0];
      root_d  = {root_q[g][ROOT_WIDTH-2:0], fits};
      rad_d   = {rad_q[g][RadW-3:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[g+1]  <= rad_d;
      rem_q[g+1]  <= rem_d;
      root_q[g+1] <= root_d;
    end
  end

  assign valid_o = vld_q[ROOT_WIDTH];
  assign root_o  = root_q[ROOT_WIDTH];

endmodule

### hdl/euclidean_distance_4d_top.sv
// Euclidean distance between two points in four dimensions. Coordinates are
// signed fixed point of COORD_WIDTH bits; distance_o is the floor square root
// of the exact sum of squared differences, in the same units as the inputs.
// A new item is taken in every cycle (busy_o stays low), and each item's result
// shows on distance_o with done_o high for one cycle. The path runs through
// registers for difference, square, pair sum and total, then through the
// square-root pipeline, which resolves one root bit per stage. The receiver
// cannot stall: results come out in order at the rate items went in and must
// be taken when done_o is high.
module euclidean_distance_4d_top
  import eucd4d_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] start_axis_one_i,
  input  logic signed [COORD_WIDTH-1:0] start_axis_two_i,
  input  logic signed [COORD_WIDTH-1:0] start_axis_three_i,
  input  logic signed [COORD_WIDTH-1:0] start_axis_four_i,
  input  logic signed [COORD_WIDTH-1:0] end_axis_one_i,
  input  logic signed [COORD_WIDTH-1:0] end_axis_two_i,
  input  logic signed [COORD_WIDTH-1:0] end_axis_three_i,
  input  logic signed [COORD_WIDTH-1:0] end_axis_four_i,
  output logic                          done_o,
  output logic [COORD_WIDTH:0]          distance_o
);

  localparam int unsigned DiffW = COORD_WIDTH + 1;
  localparam int unsigned SqW   = 2 * COORD_WIDTH;
  localparam int unsigned SumW  = 2 * COORD_WIDTH + 2;

  logic signed [COORD_WIDTH-1:0] start_w [DIMENSIONS];
  logic signed [COORD_WIDTH-1:0] end_w   [DIMENSIONS];

  logic signed [DiffW-1:0] diff_d [DIMENSIONS];
  logic signed [DiffW-1:0] diff_q [DIMENSIONS];
  logic [COORD_WIDTH-1:0]  mag_w  [DIMENSIONS];
  logic [SqW-1:0]          sq_d   [DIMENSIONS];
  logic [SqW-1:0]          sq_q   [DIMENSIONS];
  logic [SumW-1:0]         pair_d [DIMENSIONS/2];
  logic [SumW-1:0]         pair_q [DIMENSIONS/2];
  logic [SumW-1:0]         sum_d;
  logic [SumW-1:0]         sum_q;
  logic [3:0]              vld_q;

  assign busy_o = 1'b0;

  assign start_w[0] = start_axis_one_i;
  assign start_w[1] = start_axis_two_i;
  assign start_w[2] = start_axis_three_i;
  assign start_w[3] = start_axis_four_i;
  assign end_w[0]   = end_axis_one_i;
  assign end_w[1]   = end_axis_two_i;
  assign end_w[2]   = end_axis_three_i;
  assign end_w[3]   = end_axis_four_i;

  always_comb begin
    for (int k = 0; k < DIMENSIONS; k++) begin
      diff_d[k] = DiffW'(start_w[k]) - DiffW'(end_w[k]);
      mag_w[k]  = diff_q[k][DiffW-1] ? COORD_WIDTH'(-diff_q[k])
                                     : diff_q[k][COORD_WIDTH-1:0];
      sq_d[k]   = SqW'(mag_w[k]) * SqW'(mag_w[k]);
    end
    for (int p = 0; p < DIMENSIONS / 2; p++) begin
      pair_d[p] = {2'b00, sq_q[2*p]} + {2'b00, sq_q[2*p+1]};
    end
    sum_d = pair_q[0] + pair_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i & ~busy_o};
    end
  end

  // difference, square, pair sum, total
  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    sq_q   <= sq_d;
    pair_q <= pair_d;
    sum_q  <= sum_d;
  end

  eucd4d_sqrt #(
    .ROOT_WIDTH(COORD_WIDTH + 1)
  ) u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vld_q[3]),
    .radicand_i(sum_q),
    .valid_o   (done_o),
    .root_o    (distance_o)
  );

endmodule
